// ===== src/tcw_pkg.sv =====
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_PUT     = 2'd0,
    CMD_NEWLINE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  character;
    logic [7:0]  color;
    logic [10:0] cell_address;
    logic        end_of_string;
  } cmd_t;

endpackage

// ===== src/tcw_front.sv =====
module tcw_front
  import tcw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 hold_i,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [IN_DATA_W-1:0] s_tdata_i,
  input  logic                 s_tuser_i,
  input  logic                 s_tlast_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output cmd_t                 cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  assign s_tready_o = !hold_i && (!valid_q || cmd_ready_i);
  assign take       = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_d               = cmd_q;
    valid_d             = valid_q;
    if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d             = 1'b1;
      cmd_d.character     = s_tdata_i[7:0];
      cmd_d.color         = s_tdata_i[15:8];
      cmd_d.cell_address  = s_tdata_i[26:16];
      cmd_d.end_of_string = s_tlast_i;
      if (s_tuser_i) begin
        cmd_d.kind = CMD_READ;
      end else if (s_tdata_i[7:0] == NEWLINE_CHAR) begin
        cmd_d.kind = CMD_NEWLINE;
      end else begin
        cmd_d.kind = CMD_PUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ===== src/tcw_queue.sv =====
module tcw_queue
  import tcw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  // two-entry ring
  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== src/tcw_back.sv =====
module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  cmd_t                  cmd_i,
  output logic                  wipe_busy_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic                  m_tlast_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int CLW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;

  localparam logic [CNT_W-1:0] CELLS_C     = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] COLUMNS_C   = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0] BOTTOM_C    = CNT_W'(CELLS - COLUMNS);
  localparam logic [CNT_W-1:0] LAST_CELL_C = CNT_W'(CELLS - 1);
  localparam logic [CLW:0]     COL_WRAP_C  = (CLW + 1)'(COLUMNS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_COPY = 4'b0100,
    ST_WIPE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata_q;

  logic [CNT_W-1:0] cursor_q, cursor_d;
  logic [CLW-1:0]   col_q, col_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [AW-1:0]    dst_q, dst_d;
  logic             pend_wr_q, pend_wr_d;
  logic             report_q, report_d;
  logic             rd_ok_q, rd_ok_d;
  logic             eos_q, eos_d;

  logic        we;
  logic [AW-1:0] waddr;
  logic [15:0] wdata;
  logic        re;
  logic [AW-1:0] raddr;

  logic        out_valid_q;
  logic        out_load;
  logic [7:0]  out_char_d, out_color_d;
  logic        out_scrolled_d, out_last_d;
  logic [7:0]  out_char_q, out_color_q;
  logic [10:0] out_cursor_q;
  logic        out_scrolled_q, out_last_q;

  logic             out_free;
  logic             pop;
  logic [CNT_W-1:0] cur_next;
  logic [CLW-1:0]   col_next;
  logic [CLW:0]     col_inc;

  assign out_free    = !out_valid_q || m_tready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign wipe_busy_o = (state_q == ST_WIPE) && !report_q;
  assign col_inc     = {1'b0, col_q} + (CLW + 1)'(1);

  always_comb begin
    if (cmd_i.kind == CMD_NEWLINE) begin
      cur_next = cursor_q + COLUMNS_C - CNT_W'(col_q);
      col_next = '0;
    end else begin
      cur_next = cursor_q + CNT_W'(1);
      col_next = (col_inc == COL_WRAP_C) ? '0 : col_inc[CLW-1:0];
    end
  end

  always_comb begin
    state_d        = state_q;
    cursor_d       = cursor_q;
    col_d          = col_q;
    ptr_d          = ptr_q;
    dst_d          = dst_q;
    pend_wr_d      = 1'b0;
    report_d       = report_q;
    rd_ok_d        = rd_ok_q;
    eos_d          = eos_q;
    we             = 1'b0;
    waddr          = AW'(cursor_q);
    wdata          = {cmd_i.color, cmd_i.character};
    re             = 1'b0;
    raddr          = AW'(cmd_i.cell_address);
    out_load       = 1'b0;
    out_char_d     = '0;
    out_color_d    = '0;
    out_scrolled_d = 1'b0;
    out_last_d     = eos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          eos_d = cmd_i.end_of_string;
          if (cmd_i.kind == CMD_READ) begin
            re      = 1'b1;
            rd_ok_d = CMP_W'(cmd_i.cell_address) < CMP_W'(CELLS);
            state_d = ST_READ;
          end else begin
            we = (cmd_i.kind == CMD_PUT);
            if (cur_next >= CELLS_C) begin
              cursor_d = BOTTOM_C;
              col_d    = '0;
              ptr_d    = COLUMNS_C;
              report_d = 1'b1;
              state_d  = ST_COPY;
            end else begin
              cursor_d   = cur_next;
              col_d      = col_next;
              out_load   = 1'b1;
              out_last_d = cmd_i.end_of_string;
            end
          end
        end
      end
      ST_READ: begin
        out_load = 1'b1;
        if (rd_ok_q) begin
          out_char_d  = rdata_q[7:0];
          out_color_d = rdata_q[15:8];
        end
        state_d = ST_IDLE;
      end
      ST_COPY: begin
        // read one row ahead, write the word read last cycle
        we    = pend_wr_q;
        waddr = dst_q;
        wdata = rdata_q;
        if (ptr_q != CELLS_C) begin
          re        = 1'b1;
          raddr     = AW'(ptr_q);
          pend_wr_d = 1'b1;
          dst_d     = AW'(ptr_q - COLUMNS_C);
          ptr_d     = ptr_q + CNT_W'(1);
        end else begin
          ptr_d   = BOTTOM_C;
          state_d = ST_WIPE;
        end
      end
      ST_WIPE: begin
        we    = 1'b1;
        waddr = AW'(ptr_q);
        wdata = '0;
        ptr_d = ptr_q + CNT_W'(1);
        if (ptr_q == LAST_CELL_C) begin
          state_d        = ST_IDLE;
          report_d       = 1'b0;
          out_load       = report_q;
          out_scrolled_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WIPE;
      cursor_q    <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      pend_wr_q   <= 1'b0;
      report_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cursor_q  <= cursor_d;
      col_q     <= col_d;
      ptr_q     <= ptr_d;
      pend_wr_q <= pend_wr_d;
      report_q  <= report_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q   <= dst_d;
    rd_ok_q <= rd_ok_d;
    eos_q   <= eos_d;
    if (out_load) begin
      out_char_q     <= out_char_d;
      out_color_q    <= out_color_d;
      out_cursor_q   <= 11'(cursor_d);
      out_scrolled_q <= out_scrolled_d;
      out_last_q     <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {4'b0, out_scrolled_q, out_cursor_q, out_color_q, out_char_q};

endmodule

// ===== src/text_console_writer.sv =====
// channel  | dir | handshake                   | payload
// s_axis   | in  | s_axis_tvalid/tready        | tdata, tuser = mode, tlast = end_of_string
// m_axis   | out | m_axis_tvalid/tready        | tdata, tlast = string_done
//
// Ordinary characters and newlines are done in the back end's idle state, reads
// pass through a read state (one registered store read). A scroll walks the store
// once via its single read and write port: rows move up, then the bottom row clears.
// After reset a clearing pass writes all COLUMNS*ROWS cells, one per cycle,
// with s_axis_tready low. A front register and a two-word queue let input
// keep flowing while the back end works or the output word waits.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [7:0] character, [15:8] color, [26:16] cell_address, [31:27] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] mode
  input  logic                  s_axis_tuser_i,
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] read_character, [15:8] read_color, [26:16] cursor_cell,
  // [27] scrolled, [31:28] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o
);

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;
  logic wipe_busy;

  tcw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (wipe_busy),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .s_tlast_i   (s_axis_tlast_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .wipe_busy_o (wipe_busy),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

endmodule

// ===== tb/text_console_writer_test.sv =====
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLUMNS     = DEF_COLUMNS;
  localparam int ROWS        = DEF_ROWS;
  localparam int CELL_COUNT  = COLUMNS * ROWS;
  // clearing pass and a full scroll each walk the whole store
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  character;
    logic [7:0]  color;
    logic [10:0] cell_address;
    logic        end_of_string;
  } console_cmd_t;

  typedef struct packed {
    logic [7:0]  read_character;
    logic [7:0]  read_color;
    logic [10:0] cursor_cell;
    logic        scrolled;
    logic        string_done;
  } console_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tuser_i;
  logic                  s_axis_tlast_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  console_cmd_t  drive_cmd = '0;
  console_cmd_t  pending_cmds[$];
  console_word_t expected_words[$];

  logic [15:0] screen_cells [CELL_COUNT];
  int unsigned cursor_pos;

  int  send_idle_pct = 27;
  int  recv_idle_pct = 72;
  int  hold_request  = 0;
  int  hold_left     = 0;
  int  queued_count  = 0;
  int  taken_count   = 0;
  int  error_count   = 0;
  int  stall_cycles  = 0;
  bit  s_fire;

  assign s_axis_tdata_i = {5'b0, drive_cmd.cell_address, drive_cmd.color, drive_cmd.character};
  assign s_axis_tuser_i = drive_cmd.mode;
  assign s_axis_tlast_i = drive_cmd.end_of_string;

  text_console_writer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // console behavior: apply one command, queue the word it should produce
  task automatic apply_console_cmd(input console_cmd_t c);
    console_word_t w;
    w = '0;
    if (c.mode == MODE_PUT) begin
      if (c.character == NEWLINE_CHAR) begin
        cursor_pos = cursor_pos + COLUMNS - cursor_pos % COLUMNS;
      end else begin
        if (cursor_pos < CELL_COUNT) screen_cells[cursor_pos] = {c.color, c.character};
        cursor_pos++;
      end
      if (cursor_pos >= CELL_COUNT) begin
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_cells[i] = screen_cells[i + COLUMNS];
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen_cells[i] = '0;
        cursor_pos = CELL_COUNT - COLUMNS;
        w.scrolled = 1'b1;
      end
    end else if (c.cell_address < CELL_COUNT) begin
      {w.read_color, w.read_character} = screen_cells[c.cell_address];
    end
    w.cursor_cell = cursor_pos[10:0];
    w.string_done = c.end_of_string;
    expected_words.push_back(w);
  endtask

  task automatic push_cmd(input logic mode, input logic [7:0] ch, input logic [7:0] color,
                          input logic [10:0] addr, input logic eos);
    console_cmd_t c;
    c.mode          = mode;
    c.character     = ch;
    c.color         = color;
    c.cell_address  = addr;
    c.end_of_string = eos;
    pending_cmds.push_back(c);
    queued_count++;
  endtask

  // mostly text strings and newlines so the cursor reaches the bottom and scrolls
  task automatic queue_console_traffic(input int count);
    int made;
    int pick;
    int len;
    logic [7:0] ch;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        push_cmd(MODE_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 11'(($urandom_range(19) == 0) ? $urandom_range(2047, CELL_COUNT)
                                               : $urandom_range(CELL_COUNT - 1)),
                 1'($urandom_range(1)));
        made++;
      end else if (pick < 22) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          push_cmd(MODE_PUT, NEWLINE_CHAR, 8'($urandom_range(255)), 11'($urandom_range(2047)),
                   i == len - 1);
        made += len;
      end else if (pick < 27) begin
        push_cmd(1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 11'($urandom_range(2047)), 1'($urandom_range(1)));
        made++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          ch = 8'($urandom_range(255));
          if (ch == NEWLINE_CHAR) ch = 8'h20;
          push_cmd(MODE_PUT, ch, 8'($urandom_range(255)), 11'($urandom_range(2047)),
                   i == len - 1);
        end
        made += len;
        if ($urandom_range(99) < 60) begin
          push_cmd(MODE_PUT, NEWLINE_CHAR, 8'($urandom_range(255)), 11'($urandom_range(2047)),
                   1'b0);
          made++;
        end
      end
    end
  endtask

  // driver: new word at the falling edge once the previous one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_fire) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_cmd       <= pending_cmds.pop_front();
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver backpressure, including one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    s_fire = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (s_fire) begin
      apply_console_cmd(drive_cmd);
      taken_count++;
    end
  end

  always @(posedge clk_i) begin
    console_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, tdata", int'(m_axis_tdata_o), 0);
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata_o[7:0] !== want.read_character)
          report_mismatch("read_character", int'(m_axis_tdata_o[7:0]),
                          int'(want.read_character));
        if (m_axis_tdata_o[15:8] !== want.read_color)
          report_mismatch("read_color", int'(m_axis_tdata_o[15:8]), int'(want.read_color));
        if (m_axis_tdata_o[26:16] !== want.cursor_cell)
          report_mismatch("cursor_cell", int'(m_axis_tdata_o[26:16]), int'(want.cursor_cell));
        if (m_axis_tdata_o[27] !== want.scrolled)
          report_mismatch("scrolled", int'(m_axis_tdata_o[27]), int'(want.scrolled));
        if (m_axis_tlast_o !== want.string_done)
          report_mismatch("string_done", int'(m_axis_tlast_o), int'(want.string_done));
        if (m_axis_tdata_o[31:28] !== 4'b0)
          report_mismatch("tdata padding", int'(m_axis_tdata_o[31:28]), 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = '0;
    cursor_pos = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // field extremes, both modes, out-of-range reads, newline, ignored address on puts
    push_cmd(MODE_READ, 8'h00, 8'h00, 11'd0, 1'b0);
    push_cmd(MODE_READ, 8'hFF, 8'hFF, 11'(CELL_COUNT - 1), 1'b1);
    push_cmd(MODE_READ, 8'h00, 8'h00, 11'(CELL_COUNT), 1'b0);
    push_cmd(MODE_READ, 8'h00, 8'h00, 11'h7FF, 1'b1);
    push_cmd(MODE_PUT, 8'h00, 8'h00, 11'd0, 1'b0);
    push_cmd(MODE_PUT, 8'hFF, 8'hFF, 11'h7FF, 1'b1);
    push_cmd(MODE_PUT, 8'hA5, 8'h5A, 11'h555, 1'b0);
    push_cmd(MODE_PUT, 8'h5A, 8'hA5, 11'h2AA, 1'b0);
    push_cmd(MODE_PUT, NEWLINE_CHAR, 8'hFF, 11'h7FF, 1'b1);
    push_cmd(MODE_PUT, 8'h41, 8'h07, 11'd0, 1'b0);
    push_cmd(MODE_PUT, NEWLINE_CHAR, 8'h00, 11'd0, 1'b0);
    push_cmd(MODE_READ, NEWLINE_CHAR, 8'h00, 11'd0, 1'b0);
    push_cmd(MODE_READ, 8'h00, 8'h00, 11'd1, 1'b0);
    push_cmd(MODE_READ, 8'h00, 8'h00, 11'd2, 1'b0);
    push_cmd(MODE_READ, 8'h00, 8'h00, 11'd3, 1'b1);
    push_cmd(MODE_READ, 8'h00, 8'h00, 11'(COLUMNS), 1'b0);
    push_cmd(MODE_READ, 8'h00, 8'h00, 11'(COLUMNS + 1), 1'b0);
    push_cmd(MODE_READ, 8'h00, 8'h00, 11'(2 * COLUMNS), 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_request  = HOLD_CYCLES;
        end
      endcase
      queue_console_traffic(272);
      while (pending_cmds.size() != 0) @(negedge clk_i);
    end

    while (taken_count != queued_count || expected_words.size() != 0) @(negedge clk_i);
    repeat (30) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_writer.sv
tb/text_console_writer_test.sv
